// ===== src/wss_pkg.sv =====
package wss_pkg;

    // Capture store and token geometry
    localparam int CAPTURE_DEPTH = 64;
    localparam int TOKEN_MAX     = 8;
    localparam int CNT_W         = $clog2(CAPTURE_DEPTH);
    localparam int RAM_DEPTH     = 2 * CAPTURE_DEPTH;
    localparam int RAM_AW        = CNT_W + 1;
    localparam int WIN_W         = 8 * TOKEN_MAX;
    localparam int TLEN_W        = 4;
    localparam int TBYTES_W      = 64;
    localparam int CMP_W         = CNT_W + TLEN_W;

    // Descriptor queue between front and back
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = 1;
    localparam int QCNT_W        = 2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_TOKEN_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOKEN_BYTES  = 1'd1;

    // Marker text and printable range
    localparam logic [7:0] MARKER [4] = '{8'h40, 8'h28, 8'h23, 8'h29};
    localparam logic [7:0] PRINT_LO = 8'h20;
    localparam logic [7:0] PRINT_HI = 8'h7E;

    // One finished string waiting to be drained
    typedef struct packed {
        logic [CNT_W-1:0] len;
        logic             bank;
    } t_str_desc;

    // Front status seen by the top level
    typedef struct packed {
        logic              capturing;
        logic [QCNT_W-1:0] outstanding;
    } t_front_stat;

endpackage

// ===== src/wss_ifs.sv =====
interface wss_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface wss_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       byte_valid;
    logic       last_of_string;

    modport source (output valid, output text_byte, output byte_valid,
                    output last_of_string, input ready);
    modport sink   (input valid, input text_byte, input byte_valid,
                    input last_of_string, output ready);
endinterface

interface wss_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [wss_pkg::CFG_IDX_W-1:0]  reg_index;
    logic [wss_pkg::TBYTES_W-1:0]   wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// ===== src/wss_ram.sv =====
module wss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/wss_front.sv =====
module wss_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    wss_in_if.sink                               i_data,
    wss_cfg_if.sink                              i_cfg,
    output logic                                 o_push,
    output wss_pkg::t_str_desc                   o_desc,
    input  logic                                 i_str_done,
    output logic                                 o_wr_en,
    output logic [wss_pkg::RAM_AW-1:0]           o_wr_addr,
    output logic [7:0]                           o_wr_data,
    output wss_pkg::t_front_stat                 o_stat
);

    logic [wss_pkg::TLEN_W-1:0]   r_token_length;
    logic [wss_pkg::TBYTES_W-1:0] r_token_bytes;
    logic                         r_capturing, n_capturing;
    logic [1:0]                   r_marker_pos, n_marker_pos;
    logic [wss_pkg::CNT_W-1:0]    r_count, n_count;
    logic [wss_pkg::WIN_W-1:0]    r_window, n_window;
    logic                         r_seen, n_seen;
    logic                         r_bank, n_bank;
    logic [wss_pkg::QCNT_W-1:0]   r_outstanding, n_outstanding;

    logic                         ready;
    logic                         accept;
    logic [7:0]                   b;
    logic                         printable;
    logic [wss_pkg::TLEN_W-1:0]   len_eff;
    logic [wss_pkg::WIN_W-1:0]    win_next;
    logic [wss_pkg::CNT_W-1:0]    cnt_next;
    logic                         hit;
    logic                         push;
    logic                         wr_en;

    // Configuration is always taken.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_token_length <= '0;
            r_token_bytes  <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.reg_index)
                wss_pkg::REG_TOKEN_LENGTH: r_token_length <= i_cfg.wr_data[wss_pkg::TLEN_W-1:0];
                wss_pkg::REG_TOKEN_BYTES:  r_token_bytes  <= i_cfg.wr_data;
                default: ;
            endcase
        end
    end

    // Searching never touches the store, so it only stalls while capturing
    // with both store banks still waiting to drain.
    assign ready         = (r_outstanding < wss_pkg::QCNT_W'(wss_pkg::QUEUE_DEPTH)) || !r_capturing;
    assign i_data.ready  = ready;
    assign accept        = i_data.valid && ready;
    assign b             = i_data.data_byte;

    // Token length saturates at the token window size.
    assign len_eff = (r_token_length > wss_pkg::TLEN_W'(wss_pkg::TOKEN_MAX)) ?
                     wss_pkg::TLEN_W'(wss_pkg::TOKEN_MAX) : r_token_length;

    assign win_next = (r_window << 8) | wss_pkg::WIN_W'(b);
    assign cnt_next = r_count + 1'b1;

    // Compare the newest window against the token for every possible length.
    always_comb begin
        logic m;
        hit = 1'b0;
        for (int l = 1; l <= wss_pkg::TOKEN_MAX; l++) begin
            m = 1'b1;
            for (int i = 0; i < l; i++) begin
                if (win_next[8*(l-1-i) +: 8] != r_token_bytes[8*i +: 8]) begin
                    m = 1'b0;
                end
            end
            if (len_eff == wss_pkg::TLEN_W'(l) && m &&
                wss_pkg::CMP_W'(cnt_next) >= wss_pkg::CMP_W'(len_eff)) begin
                hit = 1'b1;
            end
        end
    end

    // Scan state update for one accepted byte.
    always_comb begin
        n_capturing  = r_capturing;
        n_marker_pos = r_marker_pos;
        n_count      = r_count;
        n_window     = r_window;
        n_seen       = r_seen;
        n_bank       = r_bank;
        push         = 1'b0;
        wr_en        = 1'b0;
        printable    = b inside {[wss_pkg::PRINT_LO:wss_pkg::PRINT_HI]};
        if (accept) begin
            if (!r_capturing) begin
                if (b == wss_pkg::MARKER[r_marker_pos]) begin
                    if (r_marker_pos == 2'd3) begin
                        n_marker_pos = '0;
                        n_capturing  = 1'b1;
                        n_count      = '0;
                        n_window     = '0;
                        n_seen       = 1'b0;
                    end else begin
                        n_marker_pos = r_marker_pos + 2'd1;
                    end
                end else begin
                    n_marker_pos = '0;
                end
            end else if (printable) begin
                if (r_count != wss_pkg::CNT_W'(wss_pkg::CAPTURE_DEPTH - 1)) begin
                    wr_en    = 1'b1;
                    n_count  = cnt_next;
                    n_window = win_next;
                    if (hit) begin
                        n_seen = 1'b1;
                    end
                end
            end else begin
                // A non-printable byte closes the string.
                n_capturing  = 1'b0;
                n_marker_pos = '0;
                if (len_eff == '0 || r_seen) begin
                    push   = 1'b1;
                    n_bank = ~r_bank;
                end
            end
        end
    end

    // Strings handed to the back and not yet fully delivered.
    always_comb begin
        case ({push, i_str_done})
            2'b10:   n_outstanding = r_outstanding + 1'b1;
            2'b01:   n_outstanding = r_outstanding - 1'b1;
            default: n_outstanding = r_outstanding;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capturing   <= 1'b0;
            r_marker_pos  <= '0;
            r_count       <= '0;
            r_window      <= '0;
            r_seen        <= 1'b0;
            r_bank        <= 1'b0;
            r_outstanding <= '0;
        end else begin
            r_capturing   <= n_capturing;
            r_marker_pos  <= n_marker_pos;
            r_count       <= n_count;
            r_window      <= n_window;
            r_seen        <= n_seen;
            r_bank        <= n_bank;
            r_outstanding <= n_outstanding;
        end
    end

    assign o_push           = push;
    assign o_desc.len       = r_count;
    assign o_desc.bank      = r_bank;
    assign o_wr_en          = wr_en;
    assign o_wr_addr        = {r_bank, r_count};
    assign o_wr_data        = b;
    assign o_stat.capturing   = r_capturing;
    assign o_stat.outstanding = r_outstanding;

endmodule

// ===== src/wss_queue.sv =====
module wss_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  wss_pkg::t_str_desc          i_desc,
    input  logic                        i_pop,
    output logic                        o_valid,
    output wss_pkg::t_str_desc          o_head,
    output logic [wss_pkg::QCNT_W-1:0]  o_count
);

    wss_pkg::t_str_desc                r_mem [wss_pkg::QUEUE_DEPTH];
    logic [wss_pkg::QPTR_W-1:0]        r_wp;
    logic [wss_pkg::QPTR_W-1:0]        r_rp;
    logic [wss_pkg::QCNT_W-1:0]        r_count;

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_desc;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rp];
    assign o_count = r_count;

endmodule

// ===== src/wss_back.sv =====
module wss_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  wss_pkg::t_str_desc          i_q_desc,
    output logic                        o_pop,
    output logic                        o_rd_en,
    output logic [wss_pkg::RAM_AW-1:0]  o_rd_addr,
    input  logic [7:0]                  i_rd_data,
    output logic                        o_str_done,
    wss_out_if.source                   o_text
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_OUT
    } t_state;

    t_state                    r_state;
    logic                      r_bank;
    logic [wss_pkg::CNT_W-1:0] r_len;
    logic [wss_pkg::CNT_W-1:0] r_idx;
    logic                      r_valid;
    logic [7:0]                r_byte;
    logic                      r_bvalid;
    logic                      r_last;

    logic                      pop;
    logic                      take;

    // Read requests: the first byte at pop, later ones as each result leaves.
    assign pop        = (r_state == ST_IDLE) && i_q_valid;
    assign take       = (r_state == ST_OUT) && o_text.ready;
    assign o_pop      = pop;
    assign o_rd_en    = (pop && i_q_desc.len != '0) || (take && !r_last);
    assign o_rd_addr  = pop ? {i_q_desc.bank, wss_pkg::CNT_W'(0)} : {r_bank, r_idx};
    assign o_str_done = take && r_last;

    // Drain sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_bank <= i_q_desc.bank;
                        r_len  <= i_q_desc.len;
                        if (i_q_desc.len == '0) begin
                            // Empty string: one result with no character.
                            r_byte   <= '0;
                            r_bvalid <= 1'b0;
                            r_last   <= 1'b1;
                            r_valid  <= 1'b1;
                            r_state  <= ST_OUT;
                        end else begin
                            r_idx   <= wss_pkg::CNT_W'(1);
                            r_state <= ST_LOAD;
                        end
                    end
                end
                ST_LOAD: begin
                    r_byte   <= i_rd_data;
                    r_bvalid <= 1'b1;
                    r_last   <= (r_idx == r_len);
                    r_valid  <= 1'b1;
                    r_state  <= ST_OUT;
                end
                ST_OUT: begin
                    if (o_text.ready) begin
                        r_valid <= 1'b0;
                        if (r_last) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= ST_LOAD;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                    r_valid <= 1'b0;
                end
            endcase
        end
    end

    assign o_text.valid          = r_valid;
    assign o_text.text_byte      = r_byte;
    assign o_text.byte_valid     = r_bvalid;
    assign o_text.last_of_string = r_last;

endmodule

// ===== src/what_string_scanner_core.sv =====
// Channel    Dir   Transaction
// i_data     in    one raw image byte (data_byte)
// o_text     out   one string result (text_byte, byte_valid, last_of_string)
// i_cfg      in    register write (reg_index, wr_data); always ready
//
// Input: one byte per cycle; while a string is being captured and two finished
// strings still wait in the store banks, i_data.ready drops until one drains.
// Output: a character result goes through a registered store read, then the
// output register, after a descriptor fetch per string; o_text stalls hold it.
// Reset is synchronous, active low; the capture store needs no clearing.
module what_string_scanner_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wss_in_if.sink     i_data,
    wss_out_if.source  o_text,
    wss_cfg_if.sink    i_cfg
);

    logic                             push;
    wss_pkg::t_str_desc               push_desc;
    logic                             str_done;
    logic                             wr_en;
    logic [wss_pkg::RAM_AW-1:0]       wr_addr;
    logic [7:0]                       wr_data;
    wss_pkg::t_front_stat             fstat;
    logic                             q_valid;
    wss_pkg::t_str_desc               q_head;
    logic [wss_pkg::QCNT_W-1:0]       q_count;
    logic                             pop;
    logic                             rd_en;
    logic [wss_pkg::RAM_AW-1:0]       rd_addr;
    logic [7:0]                       rd_data;

    // Marker search, capture and token filter
    wss_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_data     (i_data),
        .i_cfg      (i_cfg),
        .o_push     (push),
        .o_desc     (push_desc),
        .i_str_done (str_done),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_stat     (fstat)
    );

    // Two capture banks, one filling while the other drains
    wss_ram #(
        .WIDTH (8),
        .DEPTH (wss_pkg::RAM_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Finished string descriptors
    wss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_head  (q_head),
        .o_count (q_count)
    );

    // String drain
    wss_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_desc   (q_head),
        .o_pop      (pop),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data),
        .o_str_done (str_done),
        .o_text     (o_text)
    );

    // The descriptor queue never overflows.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (q_count != wss_pkg::QCNT_W'(wss_pkg::QUEUE_DEPTH)))
        else $error("descriptor queue overflow");

    // Queued strings are always counted as outstanding by the front.
    a_outstanding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= fstat.outstanding)
        else $error("outstanding count below queue fill");

    // An empty-string result is always the end of its string.
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_text.valid && !o_text.byte_valid) |-> o_text.last_of_string)
        else $error("empty result without last marker");

    // After the last result of a string leaves, the output goes quiet.
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_text.valid && o_text.ready && o_text.last_of_string) |=> !o_text.valid)
        else $error("result right after end of string");

endmodule
